@@ src/adaptive_normalized_audio_mixer_core_macros.svh @@
// ----------------------------------------------------------------------------
// anm assertion macros
// shared property wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_NORMALIZED_AUDIO_MIXER_CORE_MACROS_SVH
`define ADAPTIVE_NORMALIZED_AUDIO_MIXER_CORE_MACROS_SVH

// same-cycle implication
`define ANM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ANM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/anm_pkg.sv @@
// ----------------------------------------------------------------------------
// anm_pkg
// widths, constants and shared types of the normalized audio mixer
// ----------------------------------------------------------------------------
package anm_pkg;

  localparam int unsigned SAMPLE_FIELDS = 4;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned GAIN_W        = 7;
  localparam int unsigned ACTIVE_W      = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 7;
  localparam int unsigned SCALED_W      = 17;  // signed scaled sample
  localparam int unsigned SCALED_MAG_W  = 22;  // |sample| * gain
  localparam int unsigned SUM_W         = 19;  // signed sum of four lanes
  localparam int unsigned MAG_W         = 18;  // |sum|
  localparam int unsigned ATT_W         = 17;  // q1.16, unity included
  localparam int unsigned QUOT_W        = 16;
  localparam int unsigned RECIP_W       = 23;
  localparam int unsigned RECIP_SHIFT   = 29;

  localparam logic [GAIN_W-1:0]  GAIN_FULL  = 7'd100;
  // ceil(2^29 / 100), exact for products below 2^22
  localparam logic [RECIP_W-1:0] RECIP_100  = 23'd5368710;
  localparam logic [ATT_W-1:0]   ATT_UNITY  = 17'd65536;
  localparam int unsigned        RECOVER_SH = 5;

  localparam logic [MAG_W-1:0]      POS_LIMIT = 18'd32767;
  localparam logic [MAG_W-1:0]      NEG_LIMIT = 18'd32768;
  localparam logic [QUOT_W-1:0]     POS_NUM   = 16'd32767;
  localparam logic [QUOT_W-1:0]     NEG_NUM   = 16'd32768;
  localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd4;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/anm_lane.sv @@
// ----------------------------------------------------------------------------
// anm_lane
// scales one channel sample by its volume percentage, truncating toward zero
// ----------------------------------------------------------------------------
module anm_lane
  import anm_pkg::*;
(
  input  logic                       clk_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [GAIN_W-1:0]          gain_i,
  output logic signed [SCALED_W-1:0] scaled_o
);

  logic [GAIN_W-1:0]                  gain_sat;
  logic [SAMPLE_W-1:0]                mag;
  logic [SCALED_MAG_W-1:0]            x_d, x_q;
  logic                               neg1_q, neg2_q;
  logic [SCALED_MAG_W+RECIP_W-1:0]    recip_prod;
  logic [QUOT_W-1:0]                  quot_d, quot_q;

  // stage 1: magnitude times clamped gain
  assign gain_sat = (gain_i > GAIN_FULL) ? GAIN_FULL : gain_i;
  assign mag      = sample_i[SAMPLE_W-1] ? SAMPLE_W'(-sample_i) : SAMPLE_W'(sample_i);
  assign x_d      = SCALED_MAG_W'(mag) * SCALED_MAG_W'(gain_sat);

  // stage 2: divide by hundred through the reciprocal
  assign recip_prod = (SCALED_MAG_W+RECIP_W)'(x_q) * (SCALED_MAG_W+RECIP_W)'(RECIP_100);
  assign quot_d     = recip_prod[RECIP_SHIFT +: QUOT_W];

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    neg1_q <= sample_i[SAMPLE_W-1];
    quot_q <= quot_d;
    neg2_q <= neg1_q;
  end

  assign scaled_o = neg2_q ? -$signed(SCALED_W'(quot_q)) : $signed(SCALED_W'(quot_q));

endmodule

@@ src/anm_merge.sv @@
// ----------------------------------------------------------------------------
// anm_merge
// sums the active lanes and applies the attenuation factor
// ----------------------------------------------------------------------------
module anm_merge
  import anm_pkg::*;
#(
  parameter int unsigned NUM_LANES = 4
) (
  input  logic                       clk_i,
  input  logic signed [SCALED_W-1:0] scaled_i [NUM_LANES],
  input  logic [ACTIVE_W-1:0]        active_i,
  input  logic [ATT_W-1:0]           atten_i,
  output logic [MAG_W-1:0]           prod_o,
  output logic                       neg_o
);

  logic signed [SUM_W-1:0]     sum_d, sum_q;
  logic [MAG_W-1:0]            mag;
  logic [MAG_W+ATT_W-1:0]      full_prod;
  logic [MAG_W-1:0]            prod_q;
  logic                        neg_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (ACTIVE_W'(i) < active_i) begin
        sum_d = sum_d + SUM_W'(scaled_i[i]);
      end
    end
  end

  assign mag       = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
  assign full_prod = (MAG_W+ATT_W)'(mag) * (MAG_W+ATT_W)'(atten_i);

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    prod_q <= full_prod[16 +: MAG_W];
    neg_q  <= sum_q[SUM_W-1];
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

@@ src/anm_div.sv @@
// ----------------------------------------------------------------------------
// anm_div
// restoring divider, one quotient bit per cycle, for the clip factor
// ----------------------------------------------------------------------------
`include "adaptive_normalized_audio_mixer_core_macros.svh"

module anm_div
  import anm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctl_t          ctl_i,
  input  logic [QUOT_W-1:0] num_hi_i,  // dividend is num_hi_i * 2^16
  input  logic [MAG_W-1:0]  den_i,
  output div_stat_t         stat_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam logic [3:0] LAST_STEP = 4'(QUOT_W - 1);

  logic               busy_q, done_q;
  logic [3:0]         cnt_q;
  logic [MAG_W-1:0]   rem_q, den_q;
  logic [QUOT_W-1:0]  quot_q;
  logic [MAG_W:0]     shifted;
  logic               ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= MAG_W'(num_hi_i);
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? MAG_W'(shifted - {1'b0, den_q}) : shifted[MAG_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

  `ANM_ASSERT_NOW(a_div_no_restart, ctl_i.start, !busy_q, "divider started while busy")
  `ANM_ASSERT_NEXT(a_div_done_after_last, busy_q && (cnt_q == LAST_STEP), done_q && !busy_q,
                   "divider did not finish after last step")
  `ANM_ASSERT_NOW(a_div_done_idle, done_q, !busy_q, "divider done while busy")

endmodule

@@ src/adaptive_normalized_audio_mixer_core.sv @@
// ----------------------------------------------------------------------------
// adaptive_normalized_audio_mixer_core
// multi-channel pcm mixer with per-channel volume and adaptive attenuation
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_ready_o   sample_ch0_i .. sample_ch3_i
//  out      source     out_valid_o / out_ready_i mixed_sample_o, attenuation_now_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  the result register loads from S_DONE, after S_PIPE and S_CHECK, and after
//  S_DIV (the 16-step divider for the new factor) when the output clips; the
//  next accept comes in the cycle after the load. one word is in flight.
//  reset sets all gains to 100, two active channels and unity attenuation.
//  a result waiting on out_ready_i does not block the next accept; the block
//  only holds in its final step if the previous result is still unread.
// ----------------------------------------------------------------------------
`include "adaptive_normalized_audio_mixer_core_macros.svh"

module adaptive_normalized_audio_mixer_core
  import anm_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_ch0_i,
  input  logic signed [SAMPLE_W-1:0] sample_ch1_i,
  input  logic signed [SAMPLE_W-1:0] sample_ch2_i,
  input  logic signed [SAMPLE_W-1:0] sample_ch3_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] mixed_sample_o,
  output logic [ATT_W-1:0]           attenuation_now_o,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  // lanes beyond the sample fields that exist are never built
  localparam int unsigned NUM_LANES = (CHANNELS < SAMPLE_FIELDS) ? CHANNELS : SAMPLE_FIELDS;
  localparam logic [1:0]  PIPE_LAST = 2'd2;  // lane stage 2, sum, product

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PIPE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  // configuration registers
  logic [GAIN_W-1:0]   gain_q [SAMPLE_FIELDS];
  logic [ACTIVE_W-1:0] active_q;

  // datapath state
  logic [ATT_W-1:0]           att_q, att_d;
  logic [ATT_W-1:0]           cand_q, cand_d;   // factor before recovery
  logic signed [SAMPLE_W-1:0] mixed_q, mixed_d;

  // result register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_mixed_q;
  logic [ATT_W-1:0]           out_att_q;
  logic                       out_load;

  logic signed [SAMPLE_W-1:0] samp [SAMPLE_FIELDS];
  logic signed [SCALED_W-1:0] scaled [NUM_LANES];
  logic [MAG_W-1:0]           prod;
  logic                       neg;
  logic                       clip_pos, clip_neg;

  div_ctl_t          div_ctl;
  div_stat_t         div_stat;
  logic [QUOT_W-1:0] div_quot;

  logic [ATT_W-1:0]  recover_diff;
  logic [ATT_W-1:0]  recover_inc;
  logic [ATT_W:0]    recover_sum;
  logic [ATT_W-1:0]  att_recovered;

  assign samp[0] = sample_ch0_i;
  assign samp[1] = sample_ch1_i;
  assign samp[2] = sample_ch2_i;
  assign samp[3] = sample_ch3_i;

  // ---- configuration port, always ready ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SAMPLE_FIELDS; i++) begin
        gain_q[i] <= GAIN_FULL;
      end
      active_q <= 3'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GAIN_CH0: gain_q[0] <= cfg_data_i;
        REG_GAIN_CH1: gain_q[1] <= cfg_data_i;
        REG_GAIN_CH2: gain_q[2] <= cfg_data_i;
        REG_GAIN_CH3: gain_q[3] <= cfg_data_i;
        REG_ACTIVE:   active_q  <= cfg_data_i[ACTIVE_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---- per-channel scaling lanes, fed straight from the input ports ----
  // lane stage 1 captures on the accept edge, so the port may change after
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    anm_lane u_lane (
      .clk_i    (clk_i),
      .sample_i (samp[g]),
      .gain_i   (gain_q[g]),
      .scaled_o (scaled[g])
    );
  end

  // ---- merge: masked sum over the leading active lanes, then attenuation ----
  // lanes at or above active_q drop out, which also saturates the count
  anm_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk_i    (clk_i),
    .scaled_i (scaled),
    .active_i (active_q),
    .atten_i  (att_q),
    .prod_o   (prod),
    .neg_o    (neg)
  );

  // ---- clip detection on the unclipped output magnitude ----
  assign clip_pos = !neg && (prod > POS_LIMIT);
  assign clip_neg =  neg && (prod > NEG_LIMIT);

  // ---- new factor = limit * 2^16 / |output| ----
  anm_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl),
    .num_hi_i (clip_neg ? NEG_NUM : POS_NUM),
    .den_i    (prod),
    .stat_o   (div_stat),
    .quot_o   (div_quot)
  );

  // ---- recovery: add ceil((unity - factor) / 32) while below unity ----
  always_comb begin
    recover_diff  = ATT_UNITY - cand_q;
    recover_inc   = ATT_W'((ATT_W+1)'(recover_diff) + (ATT_W+1)'(31)) >> RECOVER_SH;
    recover_sum   = (ATT_W+1)'(cand_q) + (ATT_W+1)'(recover_inc);
    att_recovered = cand_q;
    if (cand_q < ATT_UNITY) begin
      att_recovered = (recover_sum > (ATT_W+1)'(ATT_UNITY)) ? ATT_UNITY
                                                            : recover_sum[ATT_W-1:0];
    end
  end

  // ---- sequencer ----
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cand_d        = cand_q;
    mixed_d       = mixed_q;
    att_d         = att_q;
    out_load      = 1'b0;
    div_ctl.start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PIPE;
          cnt_d   = '0;
        end
      end
      S_PIPE: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == PIPE_LAST) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (clip_pos) begin
          mixed_d = PCM_MAX;
        end else if (clip_neg) begin
          mixed_d = PCM_MIN;
        end else if (neg) begin
          mixed_d = -$signed(prod[SAMPLE_W-1:0]);
        end else begin
          mixed_d = $signed(prod[SAMPLE_W-1:0]);
        end
        if (clip_pos || clip_neg) begin
          div_ctl.start = 1'b1;
          state_d       = S_DIV;
        end else begin
          cand_d  = att_q;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          cand_d  = ATT_W'(div_quot);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait only if the previous result is still unread
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          att_d    = att_recovered;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      att_q       <= ATT_UNITY;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      att_q   <= att_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    mixed_q <= mixed_d;
    if (out_load) begin
      out_mixed_q <= mixed_q;
      out_att_q   <= att_recovered;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mixed_sample_o    = out_mixed_q;
  assign attenuation_now_o = out_att_q;

  `ANM_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o,
                   "second word accepted while one is in flight")
  `ANM_ASSERT_NEXT(a_att_only_on_result, state_q != S_DONE, $stable(att_q),
                   "attenuation changed outside result load")
  `ANM_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_q == S_DIV,
                  "divider finished outside divide step")

endmodule
